### rtl/bytecode_header_validator_unit_defines.svh
// assertion macros shared by the validator rtl
// expects clk and rst_n in the scope of each use
`ifndef BYTECODE_HEADER_VALIDATOR_UNIT_DEFINES_SVH
`define BYTECODE_HEADER_VALIDATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BHV_ASSERT_IMPLIES(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define BHV_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle implication failed");

`endif

### rtl/bhv_pkg.sv
// package for the bytecode header validator: opcodes, config indexes, types
// no dependencies
package bhv_pkg;

    localparam int MAX_INSTRUCTIONS = 24;
    localparam int OPC_W = $clog2(MAX_INSTRUCTIONS + 1);
    localparam int CNT_W = 5;
    localparam int CMP_W = (OPC_W > CNT_W) ? OPC_W : CNT_W;
    localparam logic [CNT_W-1:0] CNT_SAT = '1;
    localparam int SKIP_W = 4;
    localparam logic [SKIP_W-1:0] SKIP_MAX = 4'd8;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_QUICK_STOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INSTRUCTIONS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PUSHES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GETPCS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ADDS = 3'd4;

    localparam logic [CNT_W-1:0] RST_MIN_INSTRUCTIONS = 5'd6;
    localparam logic [CNT_W-1:0] RST_MIN_PUSHES = 5'd2;
    localparam logic [CNT_W-1:0] RST_MIN_GETPCS = 5'd2;
    localparam logic [CNT_W-1:0] RST_MIN_ADDS = 5'd2;

    localparam logic [7:0] OP_EXIT = 8'h00;
    localparam logic [7:0] OP_JUMP = 8'h02;
    localparam logic [7:0] OP_JZFWD = 8'h03;
    localparam logic [7:0] OP_JZBACK = 8'h04;
    localparam logic [7:0] OP_GETPC = 8'h06;
    localparam logic [7:0] OP_PUSH1 = 8'h09;
    localparam logic [7:0] OP_PUSH8 = 8'h0c;
    localparam logic [7:0] OP_ADD = 8'h20;
    localparam logic [7:0] OP_CHECK = 8'h30;

    typedef struct packed {
        logic             quick_stop;
        logic [CNT_W-1:0] min_instructions;
        logic [CNT_W-1:0] min_pushes;
        logic [CNT_W-1:0] min_getpcs;
        logic [CNT_W-1:0] min_adds;
    } cfg_t;

    typedef struct packed {
        logic              invalid;
        logic              term;
        logic              push;
        logic              getpc;
        logic              add;
        logic [SKIP_W-1:0] skip_len;
    } op_class_t;

    typedef struct packed {
        logic             hit;
        logic             image_valid;
        logic [CNT_W-1:0] instructions_seen;
    } result_t;

endpackage

### rtl/bhv_in_if.sv
// byte channel of the validator: valid/ready with one image byte and flags
// depends on nothing
interface bhv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output byte_value, output first_byte,
                    output last_byte, input ready);
    modport sink (input valid, input byte_value, input first_byte,
                  input last_byte, output ready);
endinterface

### rtl/bhv_out_if.sv
// verdict channel of the validator: valid/ready with the verdict payload
// depends on nothing
interface bhv_out_if;
    logic       valid;
    logic       ready;
    logic       image_valid;
    logic [4:0] instructions_seen;

    modport source (output valid, output image_valid, output instructions_seen,
                    input ready);
    modport sink (input valid, input image_valid, input instructions_seen,
                  output ready);
endinterface

### rtl/bhv_cfg.sv
// configuration registers of the validator
// depends on bhv_pkg
module bhv_cfg
    import bhv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_QUICK_STOP:       cfg_next.quick_stop = cfg_data[0];
                CFG_MIN_INSTRUCTIONS: cfg_next.min_instructions = cfg_data[CNT_W-1:0];
                CFG_MIN_PUSHES:       cfg_next.min_pushes = cfg_data[CNT_W-1:0];
                CFG_MIN_GETPCS:       cfg_next.min_getpcs = cfg_data[CNT_W-1:0];
                CFG_MIN_ADDS:         cfg_next.min_adds = cfg_data[CNT_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quick_stop <= 1'b0;
            cfg_reg.min_instructions <= RST_MIN_INSTRUCTIONS;
            cfg_reg.min_pushes <= RST_MIN_PUSHES;
            cfg_reg.min_getpcs <= RST_MIN_GETPCS;
            cfg_reg.min_adds <= RST_MIN_ADDS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/bhv_decode.sv
// opcode classifier: unassigned, block terminators, pushes, getpc, add, push immediate length
// depends on bhv_pkg
module bhv_decode
    import bhv_pkg::*;
(
    input  logic [7:0] byte_value,
    output op_class_t  op
);

    logic [7:0] push_ofs;

    always_comb
    begin
        push_ofs = byte_value - OP_PUSH1;
        op.invalid = byte_value inside {[8'h0d:8'h0f], [8'h18:8'h1f], [8'h25:8'h27],
                                        [8'h2d:8'h2f], [8'h31:8'hf7]};
        op.term = byte_value inside {OP_EXIT, OP_JUMP, OP_JZFWD, OP_JZBACK, OP_CHECK};
        op.push = byte_value inside {[OP_PUSH1:OP_PUSH8]};
        op.getpc = (byte_value == OP_GETPC);
        op.add = (byte_value == OP_ADD);
        op.skip_len = SKIP_W'(1) << push_ofs[1:0];
    end

endmodule

### rtl/bhv_scan.sv
// scan state of the first basic block and the per-byte update
// depends on bhv_pkg, bhv_decode output and the assertion macro header
`include "bytecode_header_validator_unit_defines.svh"
module bhv_scan
    import bhv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       first_byte,
    input  logic       last_byte,
    input  op_class_t  op,
    input  cfg_t       cfg,
    output result_t    res
);

    logic [SKIP_W-1:0] skip_reg, skip_next, skip_cur;
    logic [OPC_W-1:0]  opc_reg, opc_next, opc_cur;
    logic [CNT_W-1:0]  push_reg, push_next, push_cur;
    logic [CNT_W-1:0]  getpc_reg, getpc_next, getpc_cur;
    logic [CNT_W-1:0]  add_reg, add_next, add_cur;
    logic              verd_reg, verd_next, verd_cur;
    logic              fin_reg, fin_next, fin_cur;
    logic              stop;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_SAT) ? CNT_SAT : v + 1'b1;
    endfunction

    always_comb
    begin
        skip_cur = first_byte ? '0 : skip_reg;
        opc_cur = first_byte ? '0 : opc_reg;
        push_cur = first_byte ? '0 : push_reg;
        getpc_cur = first_byte ? '0 : getpc_reg;
        add_cur = first_byte ? '0 : add_reg;
        verd_cur = first_byte ? 1'b0 : verd_reg;
        fin_cur = first_byte ? 1'b0 : fin_reg;

        skip_next = skip_cur;
        opc_next = opc_cur;
        push_next = push_cur;
        getpc_next = getpc_cur;
        add_next = add_cur;
        verd_next = verd_cur;
        fin_next = fin_cur;
        stop = 1'b0;

        if (!fin_cur)
        begin
            if (skip_cur != '0)
            begin
                skip_next = skip_cur - 1'b1;
            end
            else if (op.invalid)
            begin
                verd_next = 1'b0;
                stop = 1'b1;
            end
            else
            begin
                opc_next = opc_cur + 1'b1;
                if (op.term)
                begin
                    stop = 1'b1;
                end
                else
                begin
                    if (op.push)
                    begin
                        skip_next = op.skip_len;
                    end
                    if (!verd_cur)
                    begin
                        if (op.push)
                        begin
                            push_next = sat_inc(push_cur);
                        end
                        if (op.getpc)
                        begin
                            getpc_next = sat_inc(getpc_cur);
                        end
                        if (op.add)
                        begin
                            add_next = sat_inc(add_cur);
                        end
                        verd_next = (CMP_W'(opc_next) >= CMP_W'(cfg.min_instructions))
                                    && (push_next >= cfg.min_pushes)
                                    && (getpc_next >= cfg.min_getpcs)
                                    && (add_next >= cfg.min_adds);
                    end
                    if (cfg.quick_stop && verd_next)
                    begin
                        stop = 1'b1;
                    end
                    if (opc_next >= OPC_W'(MAX_INSTRUCTIONS))
                    begin
                        stop = 1'b1;
                    end
                end
            end
            if (last_byte)
            begin
                stop = 1'b1;
            end
            fin_next = stop;
        end

        res.hit = !fin_cur && stop;
        res.image_valid = verd_next;
        res.instructions_seen = (CMP_W'(opc_next) >= CMP_W'(CNT_SAT)) ? CNT_SAT
                                : CNT_W'(opc_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= '0;
            opc_reg <= '0;
            push_reg <= '0;
            getpc_reg <= '0;
            add_reg <= '0;
            verd_reg <= 1'b0;
            fin_reg <= 1'b1;
        end
        else if (step)
        begin
            skip_reg <= skip_next;
            opc_reg <= opc_next;
            push_reg <= push_next;
            getpc_reg <= getpc_next;
            add_reg <= add_next;
            verd_reg <= verd_next;
            fin_reg <= fin_next;
        end
    end

    `BHV_ASSERT_NEXT(a_result_ends_scan, step && res.hit, fin_reg)
    `BHV_ASSERT_IMPLIES(a_opc_bound, 1'b1, opc_reg <= OPC_W'(MAX_INSTRUCTIONS))
    `BHV_ASSERT_IMPLIES(a_skip_bound, 1'b1, skip_reg <= SKIP_MAX)
    `BHV_ASSERT_NEXT(a_idle_holds, !step, $stable(opc_reg) && $stable(fin_reg))

endmodule

### rtl/bytecode_header_validator_unit.sv
// bytecode header validator: one image byte per transfer, at most one verdict per image
// a byte that ends a scan passes the input register, then its verdict is held in the result register
// throughput: one byte per cycle while the verdict channel does not stall, set by the scan state update
// a pending verdict that is not taken holds the input register, one byte deep
// reset: asynchronous active low, scan idle until a first byte, config at defaults
// depends on bhv_pkg, bhv_in_if, bhv_out_if, bhv_cfg, bhv_decode, bhv_scan
`include "bytecode_header_validator_unit_defines.svh"
module bytecode_header_validator_unit
    import bhv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bhv_in_if.sink                bytes,
    bhv_out_if.source             verdict
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_first_reg;
    logic             in_last_reg;
    logic             out_valid_reg, out_valid_next;
    logic             out_image_valid_reg;
    logic [CNT_W-1:0] out_seen_reg;
    logic             advance;
    logic             load;
    cfg_t             cfg;
    op_class_t        op;
    result_t          scan_res;

    bhv_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bhv_decode u_decode (
        .byte_value (in_byte_reg),
        .op         (op)
    );

    bhv_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .first_byte (in_first_reg),
        .last_byte  (in_last_reg),
        .op         (op),
        .cfg        (cfg),
        .res        (scan_res)
    );

    assign advance = in_valid_reg && (!out_valid_reg || verdict.ready);
    assign bytes.ready = !in_valid_reg || advance;
    assign load = bytes.valid && bytes.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (load)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && scan_res.hit)
        begin
            out_valid_next = 1'b1;
        end
        else if (verdict.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_byte_reg <= bytes.byte_value;
            in_first_reg <= bytes.first_byte;
            in_last_reg <= bytes.last_byte;
        end
        if (advance && scan_res.hit)
        begin
            out_image_valid_reg <= scan_res.image_valid;
            out_seen_reg <= scan_res.instructions_seen;
        end
    end

    assign verdict.valid = out_valid_reg;
    assign verdict.image_valid = out_image_valid_reg;
    assign verdict.instructions_seen = out_seen_reg;

    `BHV_ASSERT_NEXT(a_hit_shows_verdict, advance && scan_res.hit, verdict.valid)
    `BHV_ASSERT_NEXT(a_stall_keeps_byte, in_valid_reg && !advance, in_valid_reg)

endmodule

### dv/bhv_verdict_checker.sv
`timescale 1ns / 1ps
// verdict checker for the bytecode header validator: tracks config writes,
// predicts one verdict per scanned image and compares the verdict channel
// depends on bhv_pkg, bhv_in_if, bhv_out_if
module bhv_verdict_checker
    import bhv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bhv_in_if                     byte_ch,
    bhv_out_if                    verdict_ch,
    output int                    fail_count,
    output int                    verdicts_owed
);

    typedef struct packed {
        logic             image_valid;
        logic [CNT_W-1:0] instructions_seen;
    } verdict_t;

    cfg_t              regs;
    logic [SKIP_W-1:0] imm_left;
    logic [7:0]        op_total;
    logic [CNT_W-1:0]  n_push;
    logic [CNT_W-1:0]  n_getpc;
    logic [CNT_W-1:0]  n_add;
    logic              good;
    logic              idle;
    verdict_t          owed_q[$];

    function automatic logic unassigned_op(input logic [7:0] c);
        return (c >= 8'h0d && c <= 8'h0f) || (c >= 8'h18 && c <= 8'h1f) ||
               (c >= 8'h25 && c <= 8'h27) || (c >= 8'h2d && c <= 8'h2f) ||
               (c >= 8'h31 && c <= 8'hf7);
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == CNT_SAT) ? v : v + 1'b1;
    endfunction

    task automatic clear_scan();
        imm_left = '0;
        op_total = '0;
        n_push   = '0;
        n_getpc  = '0;
        n_add    = '0;
        good     = 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic f, input logic l);
        logic     stop;
        logic     is_push;
        verdict_t v;
        stop = 1'b0;
        if (f)
        begin
            clear_scan();
            idle = 1'b0;
        end
        if (!idle)
        begin
            if (imm_left != 0)
                imm_left = imm_left - 1'b1;
            else if (unassigned_op(c))
            begin
                good = 1'b0;
                stop = 1'b1;
            end
            else
            begin
                op_total = op_total + 1'b1;
                if (c == OP_EXIT || c == OP_JUMP || c == OP_JZFWD || c == OP_JZBACK ||
                    c == OP_CHECK)
                    stop = 1'b1;
                else
                begin
                    is_push = (c >= OP_PUSH1 && c <= OP_PUSH8);
                    if (is_push)
                        imm_left = SKIP_W'(1) << (c - OP_PUSH1);
                    if (!good)
                    begin
                        if (is_push)
                            n_push = bump(n_push);
                        if (c == OP_GETPC)
                            n_getpc = bump(n_getpc);
                        if (c == OP_ADD)
                            n_add = bump(n_add);
                        good = (op_total >= regs.min_instructions) &&
                               (n_push >= regs.min_pushes) &&
                               (n_getpc >= regs.min_getpcs) &&
                               (n_add >= regs.min_adds);
                    end
                    if (regs.quick_stop && good)
                        stop = 1'b1;
                    if (op_total >= MAX_INSTRUCTIONS)
                        stop = 1'b1;
                end
            end
            if (l)
                stop = 1'b1;
            if (stop)
            begin
                idle = 1'b1;
                v.image_valid = good;
                v.instructions_seen = (op_total < 8'd31) ? op_total[CNT_W-1:0] : CNT_SAT;
                owed_q.push_back(v);
            end
        end
    endtask

    // valid and ready are stable at the falling edge, so a transfer seen here
    // takes place at the next rising edge
    always @(negedge clk)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            regs.quick_stop       = 1'b0;
            regs.min_instructions = RST_MIN_INSTRUCTIONS;
            regs.min_pushes       = RST_MIN_PUSHES;
            regs.min_getpcs       = RST_MIN_GETPCS;
            regs.min_adds         = RST_MIN_ADDS;
            clear_scan();
            idle = 1'b1;
            owed_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_QUICK_STOP:       regs.quick_stop = cfg_data[0];
                    CFG_MIN_INSTRUCTIONS: regs.min_instructions = cfg_data;
                    CFG_MIN_PUSHES:       regs.min_pushes = cfg_data;
                    CFG_MIN_GETPCS:       regs.min_getpcs = cfg_data;
                    CFG_MIN_ADDS:         regs.min_adds = cfg_data;
                    default:              ;
                endcase
            end
            if (byte_ch.valid && byte_ch.ready)
                scan_byte(byte_ch.byte_value, byte_ch.first_byte, byte_ch.last_byte);
            if (verdict_ch.valid && verdict_ch.ready)
            begin
                if (owed_q.size() == 0)
                    report_mismatch($sformatf("verdict %0b/%0d with none owed",
                                              verdict_ch.image_valid,
                                              verdict_ch.instructions_seen));
                else
                begin
                    want = owed_q.pop_front();
                    if (verdict_ch.image_valid !== want.image_valid)
                        report_mismatch($sformatf("image_valid %b, wanted %b",
                                                  verdict_ch.image_valid, want.image_valid));
                    if (verdict_ch.instructions_seen !== want.instructions_seen)
                        report_mismatch($sformatf("instructions_seen %0d, wanted %0d",
                                                  verdict_ch.instructions_seen,
                                                  want.instructions_seen));
                end
            end
        end
        verdicts_owed = owed_q.size();
    end

endmodule

### dv/bytecode_header_validator_unit_tb.sv
`timescale 1ns / 1ps
// top of the bytecode header validator testbench: clock, reset, config phases
// and byte stimulus; checking is done by bhv_verdict_checker
// depends on bhv_pkg, bhv_in_if, bhv_out_if, bhv_verdict_checker and the rtl
module bytecode_header_validator_unit_tb;
    import bhv_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASES       = 8;
    localparam int PHASE_BYTES  = 224;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    steady;
    int                    fail_count;
    int                    verdicts_owed;
    int                    quiet_cycles;
    logic [7:0]            img[$];

    bhv_in_if  byte_ch ();
    bhv_out_if verdict_ch ();

    bytecode_header_validator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bytes     (byte_ch),
        .verdict   (verdict_ch)
    );

    bhv_verdict_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .byte_ch       (byte_ch),
        .verdict_ch    (verdict_ch),
        .fail_count    (fail_count),
        .verdicts_owed (verdicts_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            verdict_ch.ready <= 1'b0;
        else
            verdict_ch.ready <= steady || ($urandom_range(99) >= 36);
    end

    always @(negedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
        logic took;
        while (!steady && $urandom_range(99) < 36)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.byte_value <= b;
        byte_ch.first_byte <= f;
        byte_ch.last_byte  <= l;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = byte_ch.ready;
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        while (verdicts_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic q, input logic [CNT_W-1:0] mi,
                                 input logic [CNT_W-1:0] mp, input logic [CNT_W-1:0] mg,
                                 input logic [CNT_W-1:0] ma);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_QUICK_STOP;
        cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, q};
        @(posedge clk);
        cfg_index <= CFG_MIN_INSTRUCTIONS;
        cfg_data  <= mi;
        @(posedge clk);
        cfg_index <= CFG_MIN_PUSHES;
        cfg_data  <= mp;
        @(posedge clk);
        cfg_index <= CFG_MIN_GETPCS;
        cfg_data  <= mg;
        @(posedge clk);
        cfg_index <= CFG_MIN_ADDS;
        cfg_data  <= ma;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] plain_op();
        case ($urandom_range(9))
            0, 1: return OP_GETPC;
            2, 3: return OP_ADD;
            4, 5: return OP_PUSH1 + 8'($urandom_range(3));
            6:
            begin
                case ($urandom_range(3))
                    0: return 8'h01;
                    1: return 8'h05;
                    2: return 8'h07;
                    default: return 8'h08;
                endcase
            end
            7: return 8'h10 + 8'($urandom_range(7));
            8: return ($urandom_range(1) == 0) ? 8'h21 + 8'($urandom_range(3)) :
                                                 8'h28 + 8'($urandom_range(4));
            default: return 8'hf8 + 8'($urandom_range(7));
        endcase
    endfunction

    function automatic logic [7:0] stop_op();
        case ($urandom_range(4))
            0: return OP_EXIT;
            1: return OP_JUMP;
            2: return OP_JZFWD;
            3: return OP_JZBACK;
            default: return OP_CHECK;
        endcase
    endfunction

    function automatic logic [7:0] bad_op();
        case ($urandom_range(4))
            0: return 8'h0d + 8'($urandom_range(2));
            1: return 8'h18 + 8'($urandom_range(7));
            2: return 8'h25 + 8'($urandom_range(2));
            3: return 8'h2d + 8'($urandom_range(2));
            default: return 8'h31 + 8'($urandom_range(8'hf7 - 8'h31));
        endcase
    endfunction

    // opcode stream with immediates, then a stop opcode, a bad one or nothing, then up to two random bytes
    task automatic build_image();
        int         n_ops;
        int         kind;
        logic [7:0] op;
        img.delete();
        n_ops = ($urandom_range(3) == 0) ? $urandom_range(28, 18) : $urandom_range(14, 1);
        repeat (n_ops)
        begin
            op = plain_op();
            img.push_back(op);
            if (op >= OP_PUSH1 && op <= OP_PUSH8)
                repeat (1 << (op - OP_PUSH1)) img.push_back(8'($urandom_range(255)));
        end
        kind = $urandom_range(9);
        if (kind < 4)
            img.push_back(stop_op());
        else if (kind < 6)
            img.push_back(bad_op());
        repeat ($urandom_range(2)) img.push_back(8'($urandom_range(255)));
    endtask

    task automatic run_random(input int budget);
        int sent;
        int pick;
        int cut;
        int k;
        bit with_last;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                repeat ($urandom_range(4, 1))
                    send_byte(8'($urandom_range(255)), $urandom_range(3) == 0,
                              $urandom_range(7) == 0);
            end
            else
            begin
                build_image();
                cut = img.size();
                if (pick < 22)
                    cut = $urandom_range(img.size(), 1);
                with_last = ($urandom_range(9) != 0);
                for (k = 0; k < cut; k++)
                    send_byte(img[k], k == 0, with_last && (k == cut - 1));
                sent += cut;
            end
        end
    endtask

    function automatic logic [CNT_W-1:0] rand_min();
        return ($urandom_range(3) == 0) ? CNT_W'($urandom_range(24)) :
                                          CNT_W'($urandom_range(5));
    endfunction

    initial
    begin
        int phase;
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_QUICK_STOP;
        cfg_data              = '0;
        steady                = 1'b0;
        byte_ch.valid         = 1'b0;
        byte_ch.byte_value    = '0;
        byte_ch.first_byte    = 1'b0;
        byte_ch.last_byte     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: idle byte, bad first opcode, last on an immediate,
        // every stop opcode, restart mid-scan, trailing bytes after a stop
        send_byte(OP_GETPC, 1'b0, 1'b0);
        send_byte(8'h0f, 1'b1, 1'b0);
        send_byte(OP_PUSH1, 1'b1, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(OP_GETPC, 1'b0, 1'b1);
        send_byte(OP_PUSH8, 1'b1, 1'b0);
        send_byte(8'h31, 1'b0, 1'b0);
        send_byte(8'hf7, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(OP_ADD, 1'b1, 1'b0);
        send_byte(OP_EXIT, 1'b0, 1'b0);
        send_byte(OP_GETPC, 1'b0, 1'b1);
        send_byte(OP_GETPC, 1'b1, 1'b0);
        send_byte(OP_CHECK, 1'b1, 1'b0);
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(OP_JUMP, 1'b0, 1'b1);
        send_byte(OP_JZFWD, 1'b1, 1'b0);
        send_byte(OP_JZBACK, 1'b1, 1'b1);
        send_byte(8'hf7, 1'b1, 1'b1);
        send_byte(8'h31, 1'b1, 1'b0);
        send_byte(8'h18, 1'b1, 1'b0);
        run_random(PHASE_BYTES);

        for (phase = 1; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                1: load_settings(1'b1, 5'd0, 5'd0, 5'd0, 5'd0);
                2: load_settings(1'b0, 5'd24, 5'd24, 5'd24, 5'd24);
                3: load_settings(1'b1, RST_MIN_INSTRUCTIONS, RST_MIN_PUSHES,
                                 RST_MIN_GETPCS, RST_MIN_ADDS);
                default: load_settings($urandom_range(1), rand_min(), rand_min(),
                                       rand_min(), rand_min());
            endcase
            steady = (phase == 3);
            run_random(PHASE_BYTES);
            steady = 1'b0;
        end

        wait_idle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
